[rtl/urd_pkg.sv]
// ----------------------------------------------------------------------------
// urd_pkg
// Shared widths and payload types of the unsigned restoring divider.
// ----------------------------------------------------------------------------
package urd_pkg;

	localparam int WIDTH = 32;

	typedef struct packed {
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
	} urd_req_t;

	typedef struct packed {
		logic [WIDTH-1:0] quotient;
		logic [WIDTH-1:0] remainder;
		logic             divide_by_zero;
	} urd_rsp_t;

	// qn holds the dividend bits still to be consumed at the top and the
	// quotient bits already produced at the bottom.
	typedef struct packed {
		logic [WIDTH-1:0] rem;
		logic [WIDTH-1:0] qn;
		logic [WIDTH-1:0] den;
		logic             dz;
	} urd_work_t;

endpackage

[rtl/urd_step.sv]
// ----------------------------------------------------------------------------
// urd_step
// One restoring division step: shift in a dividend bit, try the subtract.
// ----------------------------------------------------------------------------
module urd_step
	import urd_pkg::*;
(
	input  urd_work_t cur,
	output urd_work_t nxt
);

	logic [WIDTH:0]   trial;
	logic [WIDTH-1:0] diff;
	logic             ge;

	// The bit shifted out of the remainder lands in trial[WIDTH], so the
	// compare stays exact without a separate carry.
	assign trial = {cur.rem, cur.qn[WIDTH-1]};
	assign diff  = trial[WIDTH-1:0] - cur.den;
	assign ge    = (trial >= {1'b0, cur.den});

	always_comb begin
		nxt     = cur;
		nxt.rem = ge ? diff : trial[WIDTH-1:0];
		nxt.qn  = {cur.qn[WIDTH-2:0], ge};
	end

endmodule

[rtl/unsigned_restoring_divider.sv]
// ----------------------------------------------------------------------------
// unsigned_restoring_divider
// Fully pipelined radix-2 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | urd_req_t (dividend, divisor)
//  rsp     | out       | rsp_valid / rsp_ready  | urd_rsp_t (quotient, remainder,
//          |           |                        |            divide_by_zero)
//
// One request is taken per cycle unless a stalled response backs up the pipe;
// each request passes one stage per quotient bit, then the output register.
// Each stage has its own valid bit and moves when the next stage is empty or
// moving, so bubbles close up and a stalled response holds only the stages
// behind it. Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unsigned_restoring_divider
	import urd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  urd_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output urd_rsp_t rsp
);

	urd_work_t in_work;
	logic      pipe_valid_s [1:WIDTH];
	urd_work_t pipe_work_s  [1:WIDTH];
	urd_work_t step_out     [1:WIDTH];
	logic      stage_ready  [1:WIDTH+1];

	assign in_work = {{WIDTH{1'b0}}, req.dividend, req.divisor, (req.divisor == '0)};

	assign stage_ready[WIDTH+1] = !rsp_valid || rsp_ready;
	assign req_ready            = stage_ready[1];

	for (genvar k = 1; k <= WIDTH; k++) begin : g_stage
		logic      prev_valid;
		urd_work_t prev_work;

		if (k == 1) begin : g_head
			assign prev_valid = req_valid;
			assign prev_work  = in_work;
		end else begin : g_link
			assign prev_valid = pipe_valid_s[k-1];
			assign prev_work  = pipe_work_s[k-1];
		end

		assign stage_ready[k] = !pipe_valid_s[k] || stage_ready[k+1];

		urd_step u_step (
			.cur (prev_work),
			.nxt (step_out[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe_valid_s[k] <= 1'b0;
			end else if (stage_ready[k]) begin
				pipe_valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[k] && prev_valid) begin
				pipe_work_s[k] <= step_out[k];
			end
		end
	end

	// Output register: drop quotient and remainder on a zero divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (stage_ready[WIDTH+1]) begin
			rsp_valid <= pipe_valid_s[WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_ready[WIDTH+1] && pipe_valid_s[WIDTH]) begin
			rsp.quotient       <= pipe_work_s[WIDTH].dz ? '0 : pipe_work_s[WIDTH].qn;
			rsp.remainder      <= pipe_work_s[WIDTH].dz ? '0 : pipe_work_s[WIDTH].rem;
			rsp.divide_by_zero <= pipe_work_s[WIDTH].dz;
		end
	end

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_s[WIDTH] && !pipe_work_s[WIDTH].dz
		|-> pipe_work_s[WIDTH].rem < pipe_work_s[WIDTH].den)
		else $error("final remainder not below divisor");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero
		|-> rsp.quotient == '0 && rsp.remainder == '0)
		else $error("zero divisor response carries nonzero fields");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> pipe_valid_s[1])
		else $error("accepted request missing from first stage");

	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_valid_s[WIDTH] && !stage_ready[WIDTH+1]
		|=> pipe_valid_s[WIDTH] && $stable(pipe_work_s[WIDTH]))
		else $error("last stage changed while stalled");

endmodule
